// ===== rtl/core/unh_pkg.sv =====
// Package for the unorm16 to half-precision converter.
// Shared types and constants; no dependencies.
`timescale 1ns / 1ps

package unh_pkg;

   localparam int SampleWidth = 16;
   localparam int HalfWidth   = 14;
   localparam int PosWidth    = 4;
   localparam int SigWidth    = 24;

   // Half-precision bit pattern for exactly 1.0
   localparam logic [HalfWidth-1:0] HalfOne = 14'h3C00;

   typedef struct packed {
      logic                zero;   // sample is zero
      logic                full;   // sample is full scale, quotient is 1.0
      logic [PosWidth-1:0] lead;   // position of the sample's leading one
      logic [SigWidth-1:0] sig;    // single-precision significand, hidden one included
   } norm_type;

endpackage

// ===== rtl/core/unh_norm.sv =====
// Forms the single-precision significand of sample/65535.
// The quotient's binary expansion is the sample repeated; uses unh_pkg.
`timescale 1ns / 1ps

module unh_norm import unh_pkg::*; (
   input  logic [SampleWidth-1:0] sample,
   output norm_type               norm
);

   logic [PosWidth-1:0]      lead;
   logic [PosWidth-1:0]      lshift;
   logic [2*SampleWidth-1:0] rep;
   logic [2*SampleWidth-1:0] aligned;

   always_comb begin
      lead = '0;
      for (int i = 0; i < SampleWidth; i++) begin
         if (sample[i]) begin
            lead = PosWidth'(i);
         end
      end
   end

   assign lshift  = PosWidth'(SampleWidth - 1) - lead;
   assign rep     = {sample, sample};
   assign aligned = rep << lshift;

   // Round to nearest: the expansion never terminates, so the sticky bit is always set
   // and ties cannot occur; no carry out is possible below full scale.
   assign norm.sig  = aligned[2*SampleWidth-1 -: SigWidth]
                      + SigWidth'(aligned[2*SampleWidth-1-SigWidth]);
   assign norm.lead = lead;
   assign norm.zero = (sample == '0);
   assign norm.full = (sample == '1);

endmodule

// ===== rtl/core/unh_round.sv =====
// Narrows the single-precision quotient to half precision.
// Normal results round to nearest even, denormals truncate; uses unh_pkg.
`timescale 1ns / 1ps

module unh_round import unh_pkg::*; (
   input  norm_type               norm,
   output logic [HalfWidth-1:0]   half_bits
);

   logic [22:0]          frac;
   logic [9:0]           hfrac;
   logic                 round_up;
   logic [HalfWidth-1:0] normal;
   logic [HalfWidth-1:0] denorm;

   assign frac     = norm.sig[22:0];
   assign hfrac    = frac[22:13];
   assign round_up = frac[12] && (frac[13] || (frac[11:0] != '0));
   // Biased exponent is lead-1; adding lets a fraction carry reach the exponent.
   assign normal   = {HalfWidth'(norm.lead - PosWidth'(1))} << 10;
   // Leading one at bit 0 needs a shift of 15, at bit 1 a shift of 14.
   assign denorm   = norm.lead[0] ? HalfWidth'(norm.sig >> 14) : HalfWidth'(norm.sig >> 15);

   always_comb begin
      if (norm.zero) begin
         half_bits = '0;
      end else if (norm.full) begin
         half_bits = HalfOne;
      end else if (norm.lead < PosWidth'(2)) begin
         half_bits = denorm;
      end else begin
         half_bits = normal + HalfWidth'(hfrac) + HalfWidth'(round_up);
      end
   end

endmodule

// ===== rtl/core/unorm16_to_half_converter.sv =====
// Converts an unsigned 16-bit sample to the half-precision value of sample/65535.
// The sample and its valid flag are registered first, then the result and rsp_valid in the output registers.
// Throughput: one transaction per cycle; busy stays low, a register pair bounds the path.
// Reset (synchronous, active high) clears the valid flags; no result is pending after it.
// The receiver cannot stall. Instantiates unh_norm and unh_round; uses unh_pkg.
`timescale 1ns / 1ps

module unorm16_to_half_converter import unh_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [SampleWidth-1:0] req_sample,
   output logic                   rsp_valid,
   output logic [HalfWidth-1:0]   rsp_half_bits
);

   logic                   in_valid_ff;
   logic                   in_valid_in;
   logic [SampleWidth-1:0] sample_ff;
   logic [SampleWidth-1:0] sample_in;
   logic                   out_valid_ff;
   logic                   out_valid_in;
   logic [HalfWidth-1:0]   half_ff;
   logic [HalfWidth-1:0]   half_in;
   norm_type               norm;
   logic [HalfWidth-1:0]   half_bits;

   assign busy         = 1'b0;
   assign in_valid_in  = start && !busy;
   assign sample_in    = req_sample;
   assign out_valid_in = in_valid_ff;
   assign half_in      = half_bits;

   unh_norm u_norm (
      .sample (sample_ff),
      .norm   (norm)
   );

   unh_round u_round (
      .norm      (norm),
      .half_bits (half_bits)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      half_ff   <= half_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_half_bits = half_ff;

endmodule
